// ===== sv/aesd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aesd_pkg;

  // Largest number of parameter slots counted in one control sequence
  localparam int MAX_PARAMS_DEF = 16;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int PARAM_W = 16;
  localparam int DELTA_W = 17;
  localparam int CFG_W   = 8;

  // Stream word widths: tdata padded to whole bytes
  localparam int OUT_BITS   = 2 * DELTA_W + 3 * PARAM_W + BYTE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register offsets (byte addresses)
  localparam int          PADDR_W        = 3;
  localparam logic [PADDR_W-1:0] REG_CMD_ENABLE = 3'd0;
  localparam logic [CFG_W-1:0]   CMD_ENABLE_RST = 8'hFF;

  // Terminal command codes
  typedef enum logic [2:0] {
    CMD_CHAR       = 3'd0,
    CMD_MOVE       = 3'd1,
    CMD_SET_POS    = 3'd2,
    CMD_SCROLL_UP  = 3'd3,
    CMD_SCROLL_DN  = 3'd4,
    CMD_RENDITION  = 3'd5,
    CMD_CLEAR      = 3'd6,
    CMD_NEXT_LINE  = 3'd7
  } cmd_t;

  // Parser phases
  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } phase_t;

  // One decoded result word
  typedef struct packed {
    cmd_t                      command;
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [PARAM_W-1:0]        row;
    logic [PARAM_W-1:0]        column;
    logic [PARAM_W-1:0]        amount;
    logic [BYTE_W-1:0]         character;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/aesd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesd_cfg
  import aesd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [CFG_W-1:0]   cmd_enable
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr == REG_CMD_ENABLE);

  // Write the enable mask in the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_enable <= CMD_ENABLE_RST;
    end else if (wr_hit) begin
      cmd_enable <= pwdata[CFG_W-1:0];
    end
  end

  // Read back the mask, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr == REG_CMD_ENABLE) begin
      prdata = {{(32-CFG_W){1'b0}}, cmd_enable};
    end
  end

endmodule

`default_nettype wire

// ===== sv/aesd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesd_parser
  import aesd_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic [CFG_W-1:0]  cmd_enable,
  output result_t                res,
  output logic                   res_hit
);

  localparam int SLOT_W = $clog2(MAX_PARAMS + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_PARAMS);
  localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);

  localparam logic [BYTE_W-1:0] CH_ESC  = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_CSI  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UB   = 8'h42;
  localparam logic [BYTE_W-1:0] CH_UC   = 8'h43;
  localparam logic [BYTE_W-1:0] CH_UD   = 8'h44;
  localparam logic [BYTE_W-1:0] CH_UE   = 8'h45;
  localparam logic [BYTE_W-1:0] CH_UH   = 8'h48;
  localparam logic [BYTE_W-1:0] CH_UJ   = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_US   = 8'h53;
  localparam logic [BYTE_W-1:0] CH_UT   = 8'h54;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LM   = 8'h6D;

  localparam logic [PARAM_W-1:0] PARAM_SAT = '1;

  phase_t             phase, phase_next;
  logic [PARAM_W-1:0] first_param, first_param_next;
  logic [PARAM_W-1:0] second_param, second_param_next;
  logic [SLOT_W-1:0]  param_slot, param_slot_next;

  logic               dec_char;
  logic [3:0]         digit;
  logic [PARAM_W-1:0] acc_in;
  logic [PARAM_W-1:0] acc_out;
  logic [PARAM_W+4:0] acc_wide;
  logic [DELTA_W-1:0] p0_ext;
  logic [DELTA_W-1:0] p0_neg;
  logic               hit;

  assign dec_char = (byte_in >= CH_0) && (byte_in <= CH_9);
  assign digit    = 4'(byte_in - CH_0);

  // Decimal accumulate with saturation: v*10 + d
  assign acc_in   = (param_slot == '0) ? first_param : second_param;
  assign acc_wide = ({5'd0, acc_in} << 3) + ({5'd0, acc_in} << 1) + {{(PARAM_W+1){1'b0}}, digit};
  assign acc_out  = (acc_wide > {5'd0, PARAM_SAT}) ? PARAM_SAT : acc_wide[PARAM_W-1:0];

  assign p0_ext = {1'b0, first_param};
  assign p0_neg = '0 - p0_ext;

  // Next state and decoded result for the current byte
  always_comb begin
    phase_next        = phase;
    first_param_next  = first_param;
    second_param_next = second_param;
    param_slot_next   = param_slot;
    hit               = 1'b0;
    res               = '0;
    res.command       = CMD_CHAR;

    case (phase)
      PH_ESC: begin
        if (byte_in == CH_CSI) begin
          phase_next        = PH_CSI;
          first_param_next  = '0;
          second_param_next = '0;
          param_slot_next   = '0;
        end else if (byte_in != CH_ESC) begin
          phase_next = PH_GROUND;
          hit        = 1'b1;
          if (byte_in == CH_UE) begin
            res.command = CMD_NEXT_LINE;
          end else begin
            res.character = byte_in;
          end
        end
      end
      PH_CSI: begin
        if (param_slot < SLOT_LAST && byte_in == CH_SEMI) begin
          param_slot_next = param_slot + SLOT_ONE;
        end else if (param_slot < SLOT_LAST && dec_char) begin
          if (param_slot == '0) begin
            first_param_next = acc_out;
          end else if (param_slot == SLOT_ONE) begin
            second_param_next = acc_out;
          end
        end else begin
          // Final byte: pick the command
          phase_next = PH_GROUND;
          case (byte_in)
            CH_UA: begin
              hit = 1'b1; res.command = CMD_MOVE; res.delta_y = p0_neg;
            end
            CH_UB: begin
              hit = 1'b1; res.command = CMD_MOVE; res.delta_y = p0_ext;
            end
            CH_UC: begin
              hit = 1'b1; res.command = CMD_MOVE; res.delta_x = p0_ext;
            end
            CH_UD: begin
              hit = 1'b1; res.command = CMD_MOVE; res.delta_x = p0_neg;
            end
            CH_UH, CH_LF: begin
              hit = 1'b1; res.command = CMD_SET_POS;
              res.row = first_param; res.column = second_param;
            end
            CH_US: begin
              hit = 1'b1; res.command = CMD_SCROLL_UP; res.amount = first_param;
            end
            CH_UT: begin
              hit = 1'b1; res.command = CMD_SCROLL_DN; res.amount = first_param;
            end
            CH_LM: begin
              hit = 1'b1; res.command = CMD_RENDITION; res.amount = first_param;
            end
            CH_UJ: begin
              hit = (first_param == PARAM_W'(2)); res.command = CMD_CLEAR;
            end
            default: begin
              hit = 1'b0;
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_GROUND;
        if (byte_in == CH_ESC) begin
          phase_next = PH_ESC;
        end else begin
          hit           = 1'b1;
          res.character = byte_in;
        end
      end
    endcase
  end

  // Drop results whose command is masked off
  assign res_hit = hit && cmd_enable[res.command];

  // Advance parser state once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_GROUND;
      first_param  <= '0;
      second_param <= '0;
      param_slot   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      first_param  <= first_param_next;
      second_param <= second_param_next;
      param_slot   <= param_slot_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/aesd_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesd_out
  import aesd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic                  load_hit,
  input  wire result_t               load_res,
  output logic                       can_take,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic      [2:0]            m_tuser
);

  result_t held;

  assign can_take = !m_tvalid || m_tready;

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= load_hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_hit) begin
      held <= load_res;
    end
  end

  assign m_tuser = held.command;
  assign m_tdata = {{(OUT_DATA_W-OUT_BITS){1'b0}},
                    held.character, held.amount, held.column, held.row,
                    held.delta_y, held.delta_x};

endmodule

`default_nettype wire

// ===== sv/ansi_escape_sequence_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Escape sequence decoder for a terminal byte stream. One byte is taken per
// clock while the output does not stall, and each byte yields at most one
// command word on the master side (tuser = command code, tdata = move deltas,
// position, amount, character). A byte passes an input register and then the
// parser, whose phase and parameter registers update as the byte advances
// into the output register that holds the command word until the sink takes
// it. Bytes that close no command (ESC, '[', digits, ';', unknown finals,
// masked commands) give no word. The command_enable register at byte
// address 0 masks command codes.
module ansi_escape_sequence_decoder
  import aesd_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // tdata: byte_in[7:0]
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,
  // tdata: delta_x[16:0], delta_y[33:17], row[49:34], column[65:50],
  //        amount[81:66], character[89:82], zero fill
  // tuser: command[2:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic      [2:0]            m_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              can_take;
  logic [CFG_W-1:0]  cmd_enable;
  result_t           res;
  logic              res_hit;

  assign advance  = in_vld && can_take;
  assign s_tready = !in_vld || advance;

  // Input register: hold one byte until the parser advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  aesd_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cmd_enable (cmd_enable)
  );

  aesd_parser #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .byte_in    (in_byte),
    .cmd_enable (cmd_enable),
    .res        (res),
    .res_hit    (res_hit)
  );

  aesd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .load_hit (res_hit),
    .load_res (res),
    .can_take (can_take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// ===== sv/aesd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aesd_checker
  import aesd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [2:0]            m_tuser
);

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Reset empties the result register
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Deltas are zero unless the word is a cursor move
  a_delta: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != CMD_MOVE |-> m_tdata[2*DELTA_W-1:0] == '0)
    else $error("delta set on a non-move command");

  // Character is zero unless the word is a plain character
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != CMD_CHAR |-> m_tdata[OUT_BITS-1:OUT_BITS-BYTE_W] == '0)
    else $error("character set on a control command");

endmodule

bind ansi_escape_sequence_decoder aesd_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
